/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sampler RTL.
// Depends on nothing; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/core/stws_pkg.sv */
// Types and constants of the weighted sampler.
// Depends on nothing.
package stws_pkg;
    localparam int unsigned LEAF_W  = 10;
    localparam int unsigned TOTAL_W = 42;
    localparam int unsigned FRAC_W  = 32;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_DRAW  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_LAUNCH,
        ST_WALK,
        ST_OUT
    } t_state;

    // token that travels along the chain of level cells
    typedef struct packed {
        logic                valid;
        logic [LEAF_W-1:0]   path;
        logic [TOTAL_W-1:0]  value;
    } t_token;
endpackage

/* rtl/core/stws_if.sv */
// Valid/ready channel interface carrying one word.
// Depends on nothing.
interface stws_if #(parameter int unsigned W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/stws_level.sv */
// One tree level cell: node sums of one level, a leaf-to-root step for set
// and a root-to-leaf step for draw.
// Depends on stws_pkg and assert_macros.svh.
`include "assert_macros.svh"
module stws_level #(
    parameter int unsigned LEVEL = 1,
    parameter int unsigned DEPTH = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic [DEPTH-1:0] i_clr_addr,
    input  stws_pkg::t_token i_up,
    output stws_pkg::t_token o_up,
    input  stws_pkg::t_token i_dn,
    output stws_pkg::t_token o_dn
);
    localparam int unsigned AW = LEVEL;
    localparam int unsigned NN = 1 << LEVEL;
    localparam int unsigned LW = stws_pkg::LEAF_W;

    logic [stws_pkg::TOTAL_W-1:0] mem [NN];
    logic [stws_pkg::TOTAL_W-1:0] r_rd;
    stws_pkg::t_token             r_up;
    stws_pkg::t_token             r_dn;
    logic [AW-1:0]                w_raddr;

    // read the sibling for set, the left child for draw
    always_comb begin
        if (i_up.valid) begin
            w_raddr = i_up.path[AW-1:0] ^ AW'(1);
        end else begin
            w_raddr = AW'({i_dn.path, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            mem[i_clr_addr[AW-1:0]] <= '0;
        end else if (i_up.valid) begin
            mem[i_up.path[AW-1:0]] <= i_up.value;
        end
        r_rd <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up.valid <= 1'b0;
            r_dn.valid <= 1'b0;
        end else begin
            r_up.valid <= i_up.valid;
            r_dn.valid <= i_dn.valid;
        end
        r_up.path  <= i_up.path;
        r_up.value <= i_up.value;
        r_dn.path  <= i_dn.path;
        r_dn.value <= i_dn.value;
    end

    // advance set to the parent, draw to the chosen child
    always_comb begin
        o_up.valid = r_up.valid;
        o_up.path  = r_up.path >> 1;
        o_up.value = r_up.value + r_rd;
        o_dn.valid = r_dn.valid;
        if (r_dn.value <= r_rd) begin
            o_dn.path  = {r_dn.path[LW-2:0], 1'b0};
            o_dn.value = r_dn.value;
        end else begin
            o_dn.path  = {r_dn.path[LW-2:0], 1'b1};
            o_dn.value = r_dn.value - r_rd;
        end
    end

    `ASSERT_IMPLIES(a_lvl_one_dir, i_clk, i_rst_n, i_up.valid, !i_dn.valid)
    `ASSERT_IMPLIES(a_lvl_clr, i_clk, i_rst_n, i_clr, !i_up.valid && !i_dn.valid)
    `ASSERT_NEXT(a_lvl_up, i_clk, i_rst_n, i_up.valid, o_up.valid)
    `ASSERT_NEXT(a_lvl_dn, i_clk, i_rst_n, i_dn.valid, o_dn.valid)
endmodule

/* rtl/core/sum_tree_weighted_sampler.sv */
// Weighted sampler over a binary sum tree, one word at a time. Each tree level
// is a cell in a chain: set enters at the leaf cell and climbs one level per
// cycle, draw enters at the root cell and descends one level per cycle. LVLS is
// log2 of the padded leaf count (10 at 1024 leaves). A set word is launched
// into the chain directly, a draw word first passes the registered scaling
// multiply; the result is then held until it is taken, and with the result
// taken at once the next word can be taken in the cycle after. Clear sweeps the
// level memories one address per cycle over all padded leaf addresses. An unused
// opcode, a set of a leaf at or beyond LEAVES and a draw on an empty tree go
// straight to the result. After reset the same sweep runs once before the
// first word is taken.
// leaf_index is 10 bits wide, so LEAVES goes up to 1024.
// Depends on stws_pkg, stws_if, stws_level and assert_macros.svh.
`include "assert_macros.svh"
module sum_tree_weighted_sampler #(
    parameter int unsigned LEAVES      = 1024,
    parameter int unsigned WEIGHT_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    stws_if.sink   i_cmd,
    stws_if.source o_res
);
    localparam int unsigned LVLS = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
    localparam int unsigned PAD  = 1 << LVLS;
    localparam int unsigned LW   = stws_pkg::LEAF_W;
    localparam int unsigned TW   = stws_pkg::TOTAL_W;
    localparam int unsigned FW   = stws_pkg::FRAC_W;
    localparam logic [FW-1:0] WMASK = FW'((64'd1 << WEIGHT_BITS) - 64'd1);

    stws_pkg::t_state r_st, n_st;
    logic [LVLS-1:0]  r_cnt, n_cnt;
    logic             r_rep, n_rep;
    logic             r_set, n_set;
    logic [LW-1:0]    r_leaf, n_leaf;
    logic [TW-1:0]    r_val, n_val;
    logic [TW-1:0]    r_total, n_total;
    logic [LW-1:0]    r_sel, n_sel;
    logic             r_none, n_none;
    logic [63:0]      r_plo;
    logic [TW-1:0]    r_phi;

    logic [1:0]       w_op;
    logic [LW-1:0]    w_leaf;
    logic [FW-1:0]    w_wt;
    logic [FW-1:0]    w_frac;
    logic [TW-1:0]    w_target;
    logic             w_clr;
    stws_pkg::t_token w_up_in;
    stws_pkg::t_token w_dn_in;
    stws_pkg::t_token w_up [LVLS+1];
    stws_pkg::t_token w_dn [LVLS+1];

    assign w_op   = i_cmd.data[2+LW+64-1 -: 2];
    assign w_leaf = i_cmd.data[LW+64-1 -: LW];
    assign w_wt   = i_cmd.data[63:32];
    assign w_frac = i_cmd.data[31:0];

    // scale the fraction by the low and high parts of the total
    always_ff @(posedge i_clk) begin
        r_plo <= 64'(r_val[FW-1:0]) * 64'(r_total[FW-1:0]);
        r_phi <= TW'(r_val[FW-1:0]) * TW'(r_total[TW-1:FW]);
    end

    assign w_target = r_phi + TW'(r_plo[63:FW]) + TW'(1);
    assign w_clr    = (r_st == stws_pkg::ST_CLEAR);

    always_comb begin
        w_up_in = '0;
        w_dn_in = '0;
        if (r_st == stws_pkg::ST_LAUNCH) begin
            if (r_set) begin
                w_up_in.valid = 1'b1;
                w_up_in.path  = r_leaf;
                w_up_in.value = r_val;
            end else begin
                w_dn_in.valid = 1'b1;
                w_dn_in.value = w_target;
            end
        end
    end

    assign w_up[LVLS] = w_up_in;
    assign w_dn[0]    = w_dn_in;

    for (genvar lv = 1; lv <= LVLS; lv++) begin : g_lvl
        stws_level #(
            .LEVEL(lv),
            .DEPTH(LVLS)
        ) u_lvl (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clr     (w_clr),
            .i_clr_addr(r_cnt),
            .i_up      (w_up[lv]),
            .o_up      (w_up[lv-1]),
            .i_dn      (w_dn[lv-1]),
            .o_dn      (w_dn[lv])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= stws_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_rep   <= 1'b0;
            r_total <= '0;
            r_sel   <= '0;
            r_none  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_rep   <= n_rep;
            r_total <= n_total;
            r_sel   <= n_sel;
            r_none  <= n_none;
        end
        r_set  <= n_set;
        r_leaf <= n_leaf;
        r_val  <= n_val;
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_rep   = r_rep;
        n_set   = r_set;
        n_leaf  = r_leaf;
        n_val   = r_val;
        n_total = r_total;
        n_sel   = r_sel;
        n_none  = r_none;
        unique case (r_st)
            stws_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_sel  = '0;
                    n_none = 1'b0;
                    n_leaf = w_leaf;
                    unique case (stws_pkg::t_opcode'(w_op))
                        stws_pkg::OP_SET: begin
                            n_set = 1'b1;
                            n_val = TW'(w_wt & WMASK);
                            if (32'(w_leaf) < LEAVES) begin
                                n_st = stws_pkg::ST_LAUNCH;
                            end else begin
                                n_st = stws_pkg::ST_OUT;
                            end
                        end
                        stws_pkg::OP_DRAW: begin
                            n_set = 1'b0;
                            n_val = TW'(w_frac);
                            if (r_total == '0) begin
                                n_none = 1'b1;
                                n_st   = stws_pkg::ST_OUT;
                            end else begin
                                n_st = stws_pkg::ST_MUL;
                            end
                        end
                        stws_pkg::OP_CLEAR: begin
                            n_rep = 1'b1;
                            n_cnt = '0;
                            n_st  = stws_pkg::ST_CLEAR;
                        end
                        stws_pkg::OP_NOP: begin
                            n_st = stws_pkg::ST_OUT;
                        end
                    endcase
                end
            end
            stws_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + LVLS'(1);
                if (r_cnt == LVLS'(PAD - 1)) begin
                    n_total = '0;
                    n_st    = r_rep ? stws_pkg::ST_OUT : stws_pkg::ST_IDLE;
                end
            end
            stws_pkg::ST_MUL: begin
                n_st = stws_pkg::ST_LAUNCH;
            end
            stws_pkg::ST_LAUNCH: begin
                n_st = stws_pkg::ST_WALK;
            end
            stws_pkg::ST_WALK: begin
                if (r_set && w_up[0].valid) begin
                    n_total = w_up[0].value;
                    n_st    = stws_pkg::ST_OUT;
                end
                if (!r_set && w_dn[LVLS].valid) begin
                    n_sel = w_dn[LVLS].path;
                    n_st  = stws_pkg::ST_OUT;
                end
            end
            stws_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    n_st = stws_pkg::ST_IDLE;
                end
            end
            default: n_st = stws_pkg::ST_IDLE;
        endcase
    end

    assign i_cmd.ready = (r_st == stws_pkg::ST_IDLE);
    assign o_res.valid = (r_st == stws_pkg::ST_OUT);
    assign o_res.data  = {r_sel, r_none, r_total};

    `ASSERT_IMPLIES(a_one_side, i_clk, i_rst_n, o_res.valid, !i_cmd.ready)
    `ASSERT_IMPLIES(a_none_zero, i_clk, i_rst_n, o_res.valid && r_none, r_total == '0)
    `ASSERT_NEXT(a_acc, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)
    `ASSERT_IMPLIES(a_walk_up, i_clk, i_rst_n, w_up[0].valid, r_st == stws_pkg::ST_WALK)
endmodule

/* dv/tb_sum_tree_weighted_sampler.sv */
// Self-checking bench for sum_tree_weighted_sampler: set, draw, clear and unused
// words are fed through stws_if, and each result word is checked against a sum-tree predictor.
// Depends on stws_pkg, stws_if and the sampler RTL.
`timescale 1ns / 1ps
module tb_sum_tree_weighted_sampler;

    typedef struct packed {
        stws_pkg::t_opcode op;
        logic [9:0]        leaf;
        logic [31:0]       weight;
        logic [31:0]       frac;
    } t_cmd_word;

    typedef struct packed {
        logic [9:0]  leaf;
        logic        none;
        logic [41:0] total;
    } t_res_word;

    logic i_clk;
    logic i_rst_n;

    stws_if #(.W($bits(t_cmd_word))) cmd_ch ();
    stws_if #(.W($bits(t_res_word))) res_ch ();

    sum_tree_weighted_sampler i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    logic [41:0] tree_sums[0:2046];
    t_cmd_word   pending_words[$];
    t_res_word   expected_results[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          send_gap;
    int          recv_gap;
    bit          late_phase;
    bit          drain_hold;

    function automatic void tree_clear();
        for (int n = 0; n < 2047; n++) tree_sums[n] = '0;
    endfunction

    function automatic void tree_set(logic [9:0] leaf, logic [31:0] w);
        int node;
        node = 1023 + leaf;
        tree_sums[node] = {10'd0, w};
        while (node > 0) begin
            node = (node - 1) / 2;
            tree_sums[node] = tree_sums[2*node+1] + tree_sums[2*node+2];
        end
    endfunction

    function automatic t_res_word predict_sample(t_cmd_word c);
        t_res_word   res;
        logic [73:0] prod;
        logic [41:0] target;
        int          node;
        res = '0;
        case (c.op)
            stws_pkg::OP_SET:   tree_set(c.leaf, c.weight);
            stws_pkg::OP_CLEAR: tree_clear();
            stws_pkg::OP_DRAW: begin
                if (tree_sums[0] == 0) begin
                    res.none = 1'b1;
                end else begin
                    prod   = {42'd0, c.frac} * {32'd0, tree_sums[0]};
                    target = prod[73:32] + 42'd1;
                    node   = 0;
                    while (node < 1023) begin
                        if (target <= tree_sums[2*node+1]) begin
                            node = 2*node + 1;
                        end else begin
                            target = target - tree_sums[2*node+1];
                            node   = 2*node + 2;
                        end
                    end
                    res.leaf = 10'(node - 1023);
                end
            end
            default: ;
        endcase
        res.total = tree_sums[0];
        return res;
    endfunction

    function automatic t_cmd_word mk(stws_pkg::t_opcode op, logic [9:0] leaf,
                                     logic [31:0] w, logic [31:0] r);
        t_cmd_word c;
        c.op = op; c.leaf = leaf; c.weight = w; c.frac = r;
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        t_cmd_word nxt;
        logic      v;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
            send_gap     <= 0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            v   = 1'b0;
            nxt = cmd_ch.data;
            if (cmd_ch.valid) begin
                expected_results.push_back(predict_sample(cmd_ch.data));
                words_sent = words_sent + 1;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (drain_hold && words_sent == 200 && expected_results.size() != 0) begin
                v = 1'b0;
            end else if (!late_phase && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 13);
            end else if (pending_words.size() != 0) begin
                nxt = pending_words.pop_front();
                v   = 1'b1;
            end
            cmd_ch.valid <= v;
            cmd_ch.data  <= nxt;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res_word got;
        t_res_word want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap     <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: leaf %0d/%0d no_event %0d/%0d total %0d/%0d",
                                     want.leaf, got.leaf, want.none, got.none,
                                     want.total, got.total);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap     <= recv_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (!late_phase && $urandom_range(0, 7) == 0) begin
                recv_gap     <= $urandom_range(0, 13);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int k;
        int span;
        logic [31:0] w;
        late_phase   = 1'b0;
        drain_hold   = 1'b1;
        tree_clear();
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd5, 32'hFFFFFFFF, 32'h12345678));
        pending_words.push_back(mk(stws_pkg::OP_NOP, 10'h3FF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd0, 32'hFFFFFFFF, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'h3FF, 32'hFFFFFFFF, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'hFFFFFFFF));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'h80000000));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'h7FFFFFFF));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd0, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd512, 32'd1, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'hFFFFFFFF));
        pending_words.push_back(mk(stws_pkg::OP_NOP, 10'd0, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_CLEAR, 10'd0, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'hFFFFFFFF));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd1, 32'd3, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd2, 32'd0, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'd3, 32'd5, 32'd0));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'h66666666));
        pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'd0, 32'd0, 32'h66666667));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'h2AA, 32'hAAAAAAAA, 32'h55555555));
        pending_words.push_back(mk(stws_pkg::OP_SET, 10'h155, 32'h55555555, 32'hAAAAAAAA));

        span = 1024;
        for (int i = 0; i < 380; i++) begin
            if (i % 60 == 0) span = ($urandom_range(0, 2) == 0) ? 1024 : $urandom_range(2, 16);
            k = $urandom_range(0, 99);
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom();
            if (k < 48)
                pending_words.push_back(mk(stws_pkg::OP_SET, 10'($urandom_range(0, span - 1)),
                                           w, $urandom()));
            else if (k < 90)
                pending_words.push_back(mk(stws_pkg::OP_DRAW, 10'($urandom()), $urandom(),
                                           $urandom()));
            else if (k < 93)
                pending_words.push_back(mk(stws_pkg::OP_CLEAR, 10'($urandom()), $urandom(),
                                           $urandom()));
            else
                pending_words.push_back(mk(stws_pkg::OP_NOP, 10'($urandom()), $urandom(),
                                           $urandom()));
        end

        wait (words_sent >= 340);
        late_phase = 1'b1;
        wait (pending_words.size() == 0 && !cmd_ch.valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
